### hdl/slrm_pkg.sv
// slrm_pkg: shared types and constants for the serial display register access master
// no dependencies
package slrm_pkg;

  localparam int unsigned HALF_W  = 10;
  localparam int unsigned FRAME_W = 16;
  localparam int unsigned BIT_W   = 4;

  localparam logic [HALF_W-1:0] HALF_RESET = 10'd4;

  // access codes
  localparam logic [2:0] OP_CMD_WR    = 3'd0;
  localparam logic [2:0] OP_DATA_WR   = 3'd1;
  localparam logic [2:0] OP_STATUS_RD = 3'd2;
  localparam logic [2:0] OP_DATA_RD   = 3'd3;
  localparam logic [2:0] OP_PIXEL_WR  = 3'd4;

  // prefix bytes and the fill byte sent as the second byte of a read
  localparam logic [7:0] PFX_CMD_WR    = 8'h00;
  localparam logic [7:0] PFX_DATA_WR   = 8'h80;
  localparam logic [7:0] PFX_STATUS_RD = 8'h40;
  localparam logic [7:0] PFX_DATA_RD   = 8'hC0;
  localparam logic [7:0] READ_FILL     = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOW,
    ST_HIGH,
    ST_PUSH
  } slrm_state_t;

  // controls from the sequencer to the shift engine
  typedef struct packed {
    logic               load;
    logic               sample;
    logic               shift;
    logic [FRAME_W-1:0] tx_word;
    logic [7:0]         reply;
  } slrm_shift_ctl_t;

endpackage

### hdl/slrm_if.sv
// slrm_in_if / slrm_out_if: valid-ready channels for accesses and per-frame results
// no dependencies
interface slrm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] payload;
  logic [7:0]  reply_byte;

  modport source (output valid, output op, output payload, output reply_byte, input ready);
  modport sink   (input valid, input op, input payload, input reply_byte, output ready);
endinterface

interface slrm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] prefix_sent;
  logic [7:0] second_sent;
  logic [7:0] read_value;
  logic       is_read;
  logic       last;

  modport source (output valid, output prefix_sent, output second_sent, output read_value,
                  output is_read, output last, input ready);
  modport sink   (input valid, input prefix_sent, input second_sent, input read_value,
                  input is_read, input last, output ready);
endinterface

### hdl/spi_lcd_register_access_master.sv
// spi_lcd_register_access_master: mode-3 serial register access master for a display
// depends on slrm_pkg, slrm_if, slrm_phase, slrm_shift
//
//   channel  dir  beat
//   in_ch    in   op, payload, reply_byte (one access)
//   out_ch   out  prefix_sent, second_sent, read_value, is_read, last (one frame)
//   cfg_     in   half_period_cycles write, no read-back
//
// a frame is one setup phase and then a low and a high serial clock phase per bit,
// each phase one half period long; the result is then handed over from ST_PUSH.
// a pixel write is two frames. the phase timer and the 16-bit serial shift set the frame length.
// one access is in flight at a time; a new one is taken while the last result waits.
// a stalled output holds the frame engine before the result register is written.
// reset is synchronous, active low; half period resets to 4.
module spi_lcd_register_access_master (
  input  logic                        clk,
  input  logic                        rst_n,
  slrm_in_if.sink                     in_ch,
  slrm_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [slrm_pkg::HALF_W-1:0] cfg_wdata
);

  slrm_pkg::slrm_state_t state_r, state_nxt;

  logic [slrm_pkg::HALF_W-1:0]  half_r;
  logic [slrm_pkg::BIT_W-1:0]   bit_r, bit_nxt;
  logic                         frame_r, frame_nxt;
  logic [7:0]                   pixel_hi_r, pixel_hi_nxt;
  logic [7:0]                   reply_r, reply_nxt;
  logic                         is_read_r, is_read_nxt;
  logic                         pixel_r, pixel_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [7:0]                   o_prefix_r, o_second_r, o_read_r;
  logic                         o_is_read_r, o_last_r;
  logic                         out_load;

  logic                         run;
  logic                         tick;
  logic                         accept;
  logic                         op_ok;
  logic [7:0]                   dec_prefix;
  logic [7:0]                   dec_second;
  logic                         dec_read;
  logic                         out_free;
  logic [slrm_pkg::FRAME_W-1:0] sent_word;
  logic [7:0]                   rx_byte;
  slrm_pkg::slrm_shift_ctl_t    sctl;

  assign run = (state_r == slrm_pkg::ST_SETUP) || (state_r == slrm_pkg::ST_LOW) ||
               (state_r == slrm_pkg::ST_HIGH);

  slrm_phase u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .run   (run),
    .half  (half_r),
    .tick  (tick)
  );

  slrm_shift u_shift (
    .clk       (clk),
    .ctl       (sctl),
    .sent_word (sent_word),
    .rx_byte   (rx_byte)
  );

  assign in_ch.ready = (state_r == slrm_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // access decode
  always_comb begin
    op_ok      = 1'b1;
    dec_read   = 1'b0;
    dec_prefix = slrm_pkg::PFX_DATA_WR;
    dec_second = in_ch.payload[7:0];
    case (in_ch.op)
      slrm_pkg::OP_CMD_WR: begin
        dec_prefix = slrm_pkg::PFX_CMD_WR;
      end
      slrm_pkg::OP_DATA_WR: begin
        dec_prefix = slrm_pkg::PFX_DATA_WR;
      end
      slrm_pkg::OP_STATUS_RD: begin
        dec_prefix = slrm_pkg::PFX_STATUS_RD;
        dec_second = slrm_pkg::READ_FILL;
        dec_read   = 1'b1;
      end
      slrm_pkg::OP_DATA_RD: begin
        dec_prefix = slrm_pkg::PFX_DATA_RD;
        dec_second = slrm_pkg::READ_FILL;
        dec_read   = 1'b1;
      end
      slrm_pkg::OP_PIXEL_WR: begin
        dec_prefix = slrm_pkg::PFX_DATA_WR;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    bit_nxt      = bit_r;
    frame_nxt    = frame_r;
    pixel_hi_nxt = pixel_hi_r;
    reply_nxt    = reply_r;
    is_read_nxt  = is_read_r;
    pixel_nxt    = pixel_r;
    out_load     = 1'b0;
    sctl.load    = 1'b0;
    sctl.sample  = 1'b0;
    sctl.shift   = 1'b0;
    sctl.tx_word = {dec_prefix, dec_second};
    sctl.reply   = in_ch.reply_byte;
    case (state_r)
      slrm_pkg::ST_IDLE: begin
        if (accept && op_ok) begin
          sctl.load    = 1'b1;
          pixel_hi_nxt = in_ch.payload[15:8];
          reply_nxt    = in_ch.reply_byte;
          is_read_nxt  = dec_read;
          pixel_nxt    = (in_ch.op == slrm_pkg::OP_PIXEL_WR);
          frame_nxt    = 1'b0;
          bit_nxt      = '0;
          state_nxt    = slrm_pkg::ST_SETUP;
        end
      end
      slrm_pkg::ST_SETUP: begin
        if (tick) begin
          state_nxt = slrm_pkg::ST_LOW;
        end
      end
      slrm_pkg::ST_LOW: begin
        if (tick) begin
          sctl.sample = 1'b1;
          state_nxt   = slrm_pkg::ST_HIGH;
        end
      end
      slrm_pkg::ST_HIGH: begin
        if (tick) begin
          sctl.shift = 1'b1;
          bit_nxt    = bit_r + 1'b1;
          if (bit_r == {slrm_pkg::BIT_W{1'b1}}) begin
            state_nxt = slrm_pkg::ST_PUSH;
          end else begin
            state_nxt = slrm_pkg::ST_LOW;
          end
        end
      end
      slrm_pkg::ST_PUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pixel_r && !frame_r) begin
            // second pixel frame carries the high byte
            sctl.load    = 1'b1;
            sctl.tx_word = {slrm_pkg::PFX_DATA_WR, pixel_hi_r};
            sctl.reply   = reply_r;
            frame_nxt    = 1'b1;
            bit_nxt      = '0;
            state_nxt    = slrm_pkg::ST_SETUP;
          end else begin
            state_nxt = slrm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = slrm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slrm_pkg::ST_IDLE;
      half_r      <= slrm_pkg::HALF_RESET;
      out_valid_r <= 1'b0;
      bit_r       <= '0;
      frame_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_r       <= bit_nxt;
      frame_r     <= frame_nxt;
      if (cfg_we) begin
        half_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pixel_hi_r <= pixel_hi_nxt;
    reply_r    <= reply_nxt;
    is_read_r  <= is_read_nxt;
    pixel_r    <= pixel_nxt;
    if (out_load) begin
      o_prefix_r  <= sent_word[15:8];
      o_second_r  <= sent_word[7:0];
      o_read_r    <= rx_byte;
      o_is_read_r <= is_read_r;
      o_last_r    <= !pixel_r || frame_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.prefix_sent = o_prefix_r;
  assign out_ch.second_sent = o_second_r;
  assign out_ch.read_value  = o_read_r;
  assign out_ch.is_read     = o_is_read_r;
  assign out_ch.last        = o_last_r;

endmodule

### hdl/slrm_phase.sv
// slrm_phase: phase timer, one tick per serial clock half period
// depends on slrm_pkg
module slrm_phase (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         run,
  input  logic [slrm_pkg::HALF_W-1:0]  half,
  output logic                         tick
);

  logic [slrm_pkg::HALF_W-1:0] cnt_r;
  logic [slrm_pkg::HALF_W-1:0] cnt_nxt;
  logic [slrm_pkg::HALF_W:0]   cnt_inc;

  // a half period of zero behaves as one
  assign cnt_inc = {1'b0, cnt_r} + {{slrm_pkg::HALF_W{1'b0}}, 1'b1};
  assign tick    = run && (cnt_inc >= {1'b0, half});

  always_comb begin
    if (!run || tick) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_inc[slrm_pkg::HALF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hdl/slrm_shift.sv
// slrm_shift: bit-serial frame engine, mosi/miso shift lines and capture registers
// depends on slrm_pkg
module slrm_shift (
  input  logic                           clk,
  input  slrm_pkg::slrm_shift_ctl_t      ctl,
  output logic [slrm_pkg::FRAME_W-1:0]   sent_word,
  output logic [7:0]                     rx_byte
);

  logic [slrm_pkg::FRAME_W-1:0] tx_r;
  logic [slrm_pkg::FRAME_W-1:0] dev_r;
  logic [slrm_pkg::FRAME_W-1:0] cap_r;
  logic [7:0]                   rx_r;
  logic                         mosi;
  logic                         miso;

  assign mosi = tx_r[slrm_pkg::FRAME_W-1];
  // device side drives ones during the prefix byte, then its reply
  assign miso = dev_r[slrm_pkg::FRAME_W-1];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tx_r  <= ctl.tx_word;
      dev_r <= {slrm_pkg::READ_FILL, ctl.reply};
    end else if (ctl.shift) begin
      tx_r  <= {tx_r[slrm_pkg::FRAME_W-2:0], 1'b0};
      dev_r <= {dev_r[slrm_pkg::FRAME_W-2:0], 1'b1};
    end
    // rising serial clock edge: both lines are sampled
    if (ctl.sample) begin
      cap_r <= {cap_r[slrm_pkg::FRAME_W-2:0], mosi};
      rx_r  <= {rx_r[6:0], miso};
    end
  end

  assign sent_word = cap_r;
  assign rx_byte   = rx_r;

endmodule
